// File: rtl/pending_device_table_macros.svh
// Assertion macros used by the pending device table checker.
`ifndef PENDING_DEVICE_TABLE_MACROS_SVH
`define PENDING_DEVICE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PDT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pdt_pkg.sv
// Types, constants and codes shared by the pending device table modules.
package pdt_pkg;

  localparam int PER_BUS_QUOTA  = 16;
  localparam int BUS_KINDS_HELD = 2;
  localparam int SLOTS          = PER_BUS_QUOTA * BUS_KINDS_HELD;
  localparam int IDX_W          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W          = $clog2(SLOTS + 1);

  localparam logic [1:0] BUS_PCI = 2'd1;
  localparam logic [1:0] BUS_USB = 2'd2;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_REPLAY = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CODE_STORED       = 3'd0,
    CODE_REFRESHED    = 3'd1,
    CODE_QUOTA_FULL   = 3'd2,
    CODE_NO_SLOT      = 3'd3,
    CODE_IGNORED      = 3'd4,
    CODE_REMOVED      = 3'd5,
    CODE_REPLAY_ENTRY = 3'd6,
    CODE_REPLAY_EMPTY = 3'd7
  } code_t;

  typedef struct packed {
    logic [1:0]  bus;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [7:0]  cls;
    logic [7:0]  sub;
    logic [7:0]  prot;
  } ident_t;

  typedef struct packed {
    logic       has;
    logic [7:0] major;
    logic [7:0] minor;
    logic [2:0] func;
  } loc_t;

  typedef struct packed {
    logic   valid;
    ident_t id;
    loc_t   loc;
  } entry_t;

  // Search record travelling down the row, one cell per cycle.
  typedef struct packed {
    logic             live;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [CNT_W-1:0] used;
    logic             free;
    logic [IDX_W-1:0] free_idx;
  } wave_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_DROP  = 2'd2,
    OP_SHIFT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    ident_t           key_id;
    loc_t             key_loc;
    loc_t             wr_loc;
    logic [IDX_W-1:0] wr_idx;
  } cell_cmd_t;

endpackage

// File: rtl/pdt_cell.sv
// One table slot: entry storage, match logic and one stage of the search row.
module pdt_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [pdt_pkg::IDX_W-1:0] idx,
  input  pdt_pkg::cell_cmd_t      cmd,
  input  pdt_pkg::wave_t          wave_in,
  input  pdt_pkg::entry_t         shift_in,
  output pdt_pkg::wave_t          wave_out,
  output pdt_pkg::entry_t         entry
);
  import pdt_pkg::*;

  logic  hit;
  wave_t wave_next;

  always_comb begin
    hit = entry.valid && (entry.id.bus == cmd.key_id.bus) &&
          (entry.id.vendor == cmd.key_id.vendor) &&
          (entry.id.product == cmd.key_id.product);
    if (entry.loc.has && cmd.key_loc.has) begin
      if (cmd.key_id.bus == BUS_USB) begin
        hit = hit && (entry.loc.major == cmd.key_loc.major) &&
              (entry.loc.minor == cmd.key_loc.minor);
      end else if (cmd.key_id.bus == BUS_PCI) begin
        hit = hit && (entry.loc.major == cmd.key_loc.major) &&
              (entry.loc.minor == cmd.key_loc.minor) &&
              (entry.loc.func == cmd.key_loc.func);
      end
    end
  end

  // count same-bus entries only ahead of the first match
  always_comb begin
    wave_next = wave_in;
    if (wave_in.live) begin
      if (!wave_in.hit) begin
        if (hit) begin
          wave_next.hit     = 1'b1;
          wave_next.hit_idx = idx;
        end else if (entry.valid && (entry.id.bus == cmd.key_id.bus)) begin
          wave_next.used = wave_in.used + CNT_W'(1);
        end
      end
      if (!wave_in.free && !entry.valid) begin
        wave_next.free     = 1'b1;
        wave_next.free_idx = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out    <= '0;
      entry.valid <= 1'b0;
    end else begin
      wave_out <= wave_next;
      case (cmd.op)
        OP_WRITE: begin
          if (cmd.wr_idx == idx) begin
            entry.valid <= 1'b1;
            entry.id    <= cmd.key_id;
            entry.loc   <= cmd.wr_loc;
          end
        end
        OP_DROP: begin
          if (hit) entry.valid <= 1'b0;
        end
        OP_SHIFT: begin
          entry <= shift_in;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/pdt_ctrl.sv
// Sequencer: takes input words, drives the cell row and holds the output register.
module pdt_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              action,
  input  logic [1:0]              bus_kind,
  input  logic [15:0]             vendor_code,
  input  logic [15:0]             product_code,
  input  logic [7:0]              class_value,
  input  logic [7:0]              subclass_value,
  input  logic [7:0]              protocol_value,
  input  logic                    has_location,
  input  logic [7:0]              loc_major,
  input  logic [7:0]              loc_minor,
  input  logic [2:0]              loc_func,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              code,
  output pdt_pkg::entry_t         out_entry,
  output logic                    last,
  output pdt_pkg::cell_cmd_t      cmd,
  output pdt_pkg::wave_t          wave_head,
  input  pdt_pkg::wave_t          wave_tail,
  input  logic [pdt_pkg::SLOTS-1:0] valid_vec,
  input  pdt_pkg::entry_t         head
);
  import pdt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAVE,
    S_DECIDE,
    S_REPLAY
  } state_t;

  state_t  state;
  action_t act;
  ident_t  key_id;
  loc_t    key_loc;
  loc_t    wr_loc;
  loc_t    wr_loc_next;
  wave_t   rec;
  logic    ready_flag;

  logic    out_take;
  logic    any_valid;
  logic    rest_valid;
  logic    out_load;
  code_t   load_code;
  logic    load_entry;
  logic    load_last;
  code_t   dec_code;
  logic    dec_write;

  assign in_ready   = (state == S_IDLE);
  assign out_take   = !out_valid || out_ready;
  assign any_valid  = |valid_vec;
  assign rest_valid = |(valid_vec >> 1);

  // location copy kept only for PCI and USB; USB drops the function number
  always_comb begin
    wr_loc_next = '0;
    if (has_location && (bus_kind == BUS_USB)) begin
      wr_loc_next = '{has: 1'b1, major: loc_major, minor: loc_minor, func: 3'd0};
    end else if (has_location && (bus_kind == BUS_PCI)) begin
      wr_loc_next = '{has: 1'b1, major: loc_major, minor: loc_minor, func: loc_func};
    end
  end

  always_comb begin
    dec_write = 1'b0;
    if (rec.hit) begin
      dec_code  = CODE_REFRESHED;
      dec_write = 1'b1;
    end else if (rec.used >= CNT_W'(PER_BUS_QUOTA)) begin
      dec_code = CODE_QUOTA_FULL;
    end else if (!rec.free) begin
      dec_code = CODE_NO_SLOT;
    end else begin
      dec_code  = CODE_STORED;
      dec_write = 1'b1;
    end
  end

  always_comb begin
    out_load       = 1'b0;
    load_code      = CODE_STORED;
    load_entry     = 1'b0;
    load_last      = 1'b1;
    cmd.op         = OP_NONE;
    cmd.key_id     = key_id;
    cmd.key_loc    = key_loc;
    cmd.wr_loc     = wr_loc;
    cmd.wr_idx     = rec.hit ? rec.hit_idx : rec.free_idx;
    wave_head      = '0;
    case (state)
      S_EXEC: begin
        case (act)
          ACT_HOLD: begin
            if (ready_flag) begin
              out_load  = out_take;
              load_code = CODE_IGNORED;
            end else begin
              wave_head.live = 1'b1;
            end
          end
          ACT_REMOVE: begin
            out_load  = out_take;
            load_code = CODE_REMOVED;
            if (out_take) cmd.op = OP_DROP;
          end
          ACT_REPLAY: begin
            if (!any_valid) begin
              out_load  = out_take;
              load_code = CODE_REPLAY_EMPTY;
            end
          end
          default: ;
        endcase
      end
      S_DECIDE: begin
        out_load  = out_take;
        load_code = dec_code;
        if (out_take && dec_write) cmd.op = OP_WRITE;
      end
      S_REPLAY: begin
        // empty head slots are shifted out without a result
        if (any_valid) begin
          if (!head.valid) begin
            cmd.op = OP_SHIFT;
          end else if (out_take) begin
            cmd.op     = OP_SHIFT;
            out_load   = 1'b1;
            load_code  = CODE_REPLAY_ENTRY;
            load_entry = 1'b1;
            load_last  = !rest_valid;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      ready_flag <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        code      <= load_code;
        out_entry <= load_entry ? head : '0;
        last      <= load_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act     <= action_t'(action);
            key_id  <= '{bus: bus_kind, vendor: vendor_code, product: product_code,
                         cls: class_value, sub: subclass_value, prot: protocol_value};
            key_loc <= '{has: has_location, major: loc_major, minor: loc_minor,
                         func: loc_func};
            wr_loc  <= wr_loc_next;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (act)
            ACT_HOLD: begin
              if (!ready_flag) begin
                state <= S_WAVE;
              end else if (out_take) begin
                state <= S_IDLE;
              end
            end
            ACT_REMOVE: begin
              if (out_take) state <= S_IDLE;
            end
            ACT_REPLAY: begin
              ready_flag <= 1'b1;
              if (any_valid) begin
                state <= S_REPLAY;
              end else if (out_take) begin
                state <= S_IDLE;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_WAVE: begin
          if (wave_tail.live) begin
            rec   <= wave_tail;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_take) state <= S_IDLE;
        end
        S_REPLAY: begin
          if (!any_valid) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/pending_device_table.sv
// Pending device table: a row of slot cells holding unclaimed device reports.
//
// Input channel (in_valid/in_ready) takes one word per action: hold, remove or
// replay. Output channel (out_valid/out_ready) returns result words through a
// single output register; in_ready is high only while the sequencer is idle.
// Hold: the search record walks the row one cell per clock, and the result
//   word is loaded once the record has left the last cell.
// Remove: every cell compares in parallel and matching entries are dropped.
// Replay: the whole row shifts towards slot zero one cell per clock while the
//   receiver takes words, emitting each held entry in slot order, last set on
//   the final one; at most one word per cycle, and the row is empty when the
//   drain ends. An empty table gives one replay-empty word.
// A stalled receiver holds the output register; the sequencer waits to load
// a new result and no held entry shifts out, so nothing is dropped. Once a
// replay has run, holds are ignored. Reset: all slots invalid, replay flag
// clear, no result pending; usable on the first cycle after reset.
module pending_device_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [1:0]  bus_kind,
  input  logic [15:0] vendor_code,
  input  logic [15:0] product_code,
  input  logic [7:0]  class_value,
  input  logic [7:0]  subclass_value,
  input  logic [7:0]  protocol_value,
  input  logic        has_location,
  input  logic [7:0]  loc_major,
  input  logic [7:0]  loc_minor,
  input  logic [2:0]  loc_func,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  code,
  output logic [1:0]  out_bus_kind,
  output logic [15:0] out_vendor,
  output logic [15:0] out_product,
  output logic [7:0]  out_class,
  output logic [7:0]  out_subclass,
  output logic [7:0]  out_protocol,
  output logic        out_has_location,
  output logic [7:0]  out_loc_major,
  output logic [7:0]  out_loc_minor,
  output logic [2:0]  out_loc_func,
  output logic        last
);
  import pdt_pkg::*;

  cell_cmd_t        cmd;
  wave_t            waves [SLOTS+1];
  entry_t           entries [SLOTS];
  logic [SLOTS-1:0] valid_vec;
  entry_t           out_entry;

  pdt_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .bus_kind       (bus_kind),
    .vendor_code    (vendor_code),
    .product_code   (product_code),
    .class_value    (class_value),
    .subclass_value (subclass_value),
    .protocol_value (protocol_value),
    .has_location   (has_location),
    .loc_major      (loc_major),
    .loc_minor      (loc_minor),
    .loc_func       (loc_func),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .code           (code),
    .out_entry      (out_entry),
    .last           (last),
    .cmd            (cmd),
    .wave_head      (waves[0]),
    .wave_tail      (waves[SLOTS]),
    .valid_vec      (valid_vec),
    .head           (entries[0])
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_row
    entry_t shift_src;
    if (i < SLOTS - 1) begin : g_mid
      assign shift_src = entries[i+1];
    end else begin : g_tail
      assign shift_src = '0;
    end

    pdt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .cmd      (cmd),
      .wave_in  (waves[i]),
      .shift_in (shift_src),
      .wave_out (waves[i+1]),
      .entry    (entries[i])
    );

    assign valid_vec[i] = entries[i].valid;
  end

  assign out_bus_kind     = out_entry.id.bus;
  assign out_vendor       = out_entry.id.vendor;
  assign out_product      = out_entry.id.product;
  assign out_class        = out_entry.id.cls;
  assign out_subclass     = out_entry.id.sub;
  assign out_protocol     = out_entry.id.prot;
  assign out_has_location = out_entry.loc.has;
  assign out_loc_major    = out_entry.loc.major;
  assign out_loc_minor    = out_entry.loc.minor;
  assign out_loc_func     = out_entry.loc.func;

endmodule

// File: rtl/pdt_checker.sv
// Port-level checker for the pending device table, bound to the top level.
`include "pending_device_table_macros.svh"

module pdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  code,
  input logic [15:0] out_vendor,
  input logic        out_has_location,
  input logic [7:0]  out_loc_major,
  input logic [7:0]  out_loc_minor,
  input logic [2:0]  out_loc_func,
  input logic        last
);
  import pdt_pkg::*;

  // stalled result word holds
  `PDT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(code) && $stable(last), "stalled result word changed")

  // one word in flight: no accept on the cycle after an accept
  `PDT_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready, "input accepted while busy")

  // status-only results are single words with cleared entry fields
  `PDT_ASSERT_IMPLY(a_status_word, clk, rst, out_valid && (code != CODE_REPLAY_ENTRY), last && (out_vendor == 16'd0) && (out_has_location == 1'b0), "status word malformed")

  // replayed entry without a location copy carries a zero location
  `PDT_ASSERT_IMPLY(a_loc_zero, clk, rst, out_valid && (code == CODE_REPLAY_ENTRY) && !out_has_location, (out_loc_major == 8'd0) && (out_loc_minor == 8'd0) && (out_loc_func == 3'd0), "stray location on replayed entry")

endmodule

bind pending_device_table pdt_checker u_pdt_checker (.*);
